>>> hw/rtl/http_response_header_parser_defines.svh
// Assertion macros for the HTTP response header parser checker.
// Used only by the checker file; depends on nothing else.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define HRP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define HRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hrp_pkg.sv
// Shared types, constants and text tables for the HTTP response header parser.
// No dependencies; imported by every other file except the macro header.
`timescale 1ns / 1ps

package hrp_pkg;

   localparam int LENGTH_BITS      = 32;
   localparam int KEY_NAME_MAX     = 19;
   localparam int LENGTH_KEY_LEN   = 14;
   localparam int CHUNKED_KEY_LEN  = 17;
   localparam int CHUNKED_WORD_LEN = 7;
   localparam int VERSION_LEN      = 9;

   // Byte queue between front and back; depth must be a power of two.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      ERR_OK      = 3'd0,
      ERR_VERSION = 3'd1,
      ERR_STATUS  = 3'd2,
      ERR_REASON  = 3'd3,
      ERR_END     = 3'd4,
      ERR_KEY     = 3'd5,
      ERR_VALUE   = 3'd6,
      ERR_DUP     = 3'd7
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } hrp_req_type;

   typedef struct packed {
      logic [2:0]  error_code;
      logic [9:0]  status_value;
      logic [31:0] content_length;
      logic        has_content_length;
      logic        is_chunked;
   } hrp_rsp_type;

   // One classified byte as it sits in the queue.
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lc;
      logic       last;
      logic       is_digit;
      logic       is_key;
      logic       is_reason;
   } hrp_byte_type;

   function automatic logic [7:0] version_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "H";
         4'd1:    ch = "T";
         4'd2:    ch = "T";
         4'd3:    ch = "P";
         4'd4:    ch = "/";
         4'd5:    ch = "1";
         4'd6:    ch = ".";
         4'd7:    ch = "1";
         4'd8:    ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] length_key_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "c";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "l";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] chunked_key_char(input logic [4:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd0:    ch = "t";
         5'd1:    ch = "r";
         5'd2:    ch = "a";
         5'd3:    ch = "n";
         5'd4:    ch = "s";
         5'd5:    ch = "f";
         5'd6:    ch = "e";
         5'd7:    ch = "r";
         5'd8:    ch = "-";
         5'd9:    ch = "e";
         5'd10:   ch = "n";
         5'd11:   ch = "c";
         5'd12:   ch = "o";
         5'd13:   ch = "d";
         5'd14:   ch = "i";
         5'd15:   ch = "n";
         5'd16:   ch = "g";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] chunked_word_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = "c";
         3'd1:    ch = "h";
         3'd2:    ch = "u";
         3'd3:    ch = "n";
         3'd4:    ch = "k";
         3'd5:    ch = "e";
         3'd6:    ch = "d";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/hrp_front.sv
// Front end: accepts request beats, classifies each byte and queues it.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hrp_pkg::hrp_req_type req_data,
   output logic                 head_valid,
   output hrp_pkg::hrp_byte_type head_data,
   input  logic                 head_pop
);
   import hrp_pkg::*;

   hrp_byte_type           queue_ff [FIFO_DEPTH];
   hrp_byte_type           slot_in;
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]     count_ff, count_in;
   logic                   push;
   logic                   is_upper;
   logic                   is_lower;

   always_comb begin
      is_upper          = (req_data.data_byte >= "A") && (req_data.data_byte <= "Z");
      is_lower          = (req_data.data_byte >= "a") && (req_data.data_byte <= "z");
      slot_in.data      = req_data.data_byte;
      slot_in.lc        = is_upper ? 8'(req_data.data_byte + 8'd32) : req_data.data_byte;
      slot_in.last      = req_data.last_byte;
      slot_in.is_digit  = (req_data.data_byte >= "0") && (req_data.data_byte <= "9");
      slot_in.is_key    = slot_in.is_digit || is_upper || is_lower
                          || (req_data.data_byte == "-");
      slot_in.is_reason = is_upper || is_lower || (req_data.data_byte == " ")
                          || (req_data.data_byte == "-");
   end

   assign req_ready  = (count_ff != FIFO_CW'(FIFO_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? FIFO_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = FIFO_CW'(count_ff + FIFO_CW'(push) - FIFO_CW'(head_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

>>> hw/rtl/hrp_back.sv
// Back end: runs the header grammar over queued bytes and registers the result.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  hrp_pkg::hrp_byte_type head_data,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hrp_pkg::hrp_rsp_type  rsp_data
);
   import hrp_pkg::*;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef enum logic [3:0] {
      PH_VERSION, PH_STATUS, PH_REASON, PH_LINE, PH_KEY,
      PH_LEAD, PH_VALUE, PH_BLANK, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE, KIND_LENGTH, KIND_CHUNKED
   } kind_type;

   typedef struct packed {
      logic bad;
      logic space;
      logic nonempty;
   } vflag_type;

   typedef struct packed {
      vflag_type              flags;
      logic [LENGTH_BITS-1:0] len;
      logic [2:0]             cpos;
   } vstate_type;

   typedef struct packed {
      err_type    code;
      logic [1:0] seen;
   } finish_type;

   function automatic err_type first_err(input err_type cur, input err_type code);
      return (cur == ERR_OK) ? code : cur;
   endfunction

   function automatic kind_type key_kind(input logic [4:0] kp, input logic [1:0] km);
      kind_type k;
      if (kp > 5'(KEY_NAME_MAX)) begin
         k = KIND_NONE;
      end else if (km[0] && (kp == 5'(LENGTH_KEY_LEN))) begin
         k = KIND_LENGTH;
      end else if (km[1] && (kp == 5'(CHUNKED_KEY_LEN))) begin
         k = KIND_CHUNKED;
      end else begin
         k = KIND_NONE;
      end
      return k;
   endfunction

   // One value character: trimming bookkeeping, then the digit or word check.
   function automatic vstate_type value_char(input kind_type kind, input vstate_type vs,
                                             input logic [7:0] c, input logic dig);
      vstate_type             r;
      logic [LENGTH_BITS+3:0] grown;
      r     = vs;
      grown = '0;
      if (c == CH_SP) begin
         if (vs.flags.nonempty) begin
            r.flags.space = 1'b1;
         end
      end else begin
         if (vs.flags.space) begin
            r.flags.bad = 1'b1;
         end
         r.flags.nonempty = 1'b1;
         r.flags.space    = 1'b0;
         case (kind)
            KIND_LENGTH: begin
               if (dig) begin
                  grown = ({4'b0, vs.len} << 3) + ({4'b0, vs.len} << 1)
                          + (LENGTH_BITS + 4)'(c[3:0]);
                  if (grown[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                     r.len = '1;
                  end else begin
                     r.len = grown[LENGTH_BITS-1:0];
                  end
               end else begin
                  r.flags.bad = 1'b1;
               end
            end
            KIND_CHUNKED: begin
               if ((vs.cpos < 3'(CHUNKED_WORD_LEN)) && (c == chunked_word_char(vs.cpos))) begin
                  r.cpos = 3'(vs.cpos + 3'd1);
               end else begin
                  r.flags.bad = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   function automatic finish_type finish_field(input kind_type kind, input vstate_type vs,
                                               input logic [1:0] seen);
      finish_type f;
      f.code = ERR_OK;
      f.seen = seen;
      case (kind)
         KIND_LENGTH: begin
            if (!vs.flags.nonempty || vs.flags.bad) begin
               f.code = ERR_VALUE;
            end else if (seen[0]) begin
               f.code = ERR_DUP;
            end else begin
               f.seen[0] = 1'b1;
            end
         end
         KIND_CHUNKED: begin
            if (vs.flags.bad || (vs.cpos != 3'(CHUNKED_WORD_LEN))) begin
               f.code = ERR_VALUE;
            end else if (seen[1]) begin
               f.code = ERR_DUP;
            end else begin
               f.seen[1] = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return f;
   endfunction

   phase_type              phase_ff, phase_in;
   logic [4:0]             pos_ff, pos_in;
   logic [9:0]             status_ff, status_in;
   logic [1:0]             kmatch_ff, kmatch_in;
   kind_type               kind_ff, kind_in;
   vstate_type             vs_ff, vs_in;
   logic                   pcr_ff, pcr_in;
   logic [1:0]             seen_ff, seen_in;
   err_type                err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hrp_rsp_type            rsp_data_ff, rsp_data_in;

   logic [7:0]             c;
   logic                   last;
   logic                   slot_free;
   logic                   do_key;
   logic                   do_value;
   logic [4:0]             kp_base, kp_adv;
   logic [1:0]             km_base, km_adv;
   kind_type               kind_base, kind_adv;
   vstate_type             vs_cr, vs_pre, vs_chr;
   finish_type             fin_lf, fin_last;
   logic                   ok;

   assign c         = head_data.data;
   assign last      = head_data.last;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   // A flagged byte needs room in the result register; other bytes never wait.
   assign head_pop  = head_valid && (!last || slot_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Key matching state, as seen by a byte that starts a new line or continues a key.
   always_comb begin
      kp_base   = (phase_ff == PH_LINE) ? 5'd0 : pos_ff;
      km_base   = (phase_ff == PH_LINE) ? 2'b11 : kmatch_ff;
      km_adv    = km_base;
      if ((kp_base >= 5'(LENGTH_KEY_LEN)) || (head_data.lc != length_key_char(kp_base[3:0]))) begin
         km_adv[0] = 1'b0;
      end
      if ((kp_base >= 5'(CHUNKED_KEY_LEN)) || (head_data.lc != chunked_key_char(kp_base))) begin
         km_adv[1] = 1'b0;
      end
      kp_adv    = (kp_base < 5'd31) ? 5'(kp_base + 5'd1) : kp_base;
      kind_base = key_kind(kp_base, km_base);
      kind_adv  = key_kind(kp_adv, km_adv);
   end

   // Value path: a held CR that turns out not to start CRLF counts as a value byte.
   always_comb begin
      vs_cr    = value_char(kind_ff, vs_ff, CH_CR, 1'b0);
      vs_pre   = pcr_ff ? vs_cr : vs_ff;
      vs_chr   = value_char(kind_ff, vs_pre, c, head_data.is_digit);
      fin_lf   = finish_field(kind_ff, vs_ff, seen_ff);
      fin_last = finish_field(kind_ff, vs_pre, seen_ff);
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      kmatch_in = kmatch_ff;
      kind_in   = kind_ff;
      vs_in     = vs_ff;
      pcr_in    = pcr_ff;
      seen_in   = seen_ff;
      err_in    = err_ff;
      do_key    = 1'b0;
      do_value  = 1'b0;

      if (err_ff == ERR_OK) begin
         case (phase_ff)
            PH_VERSION: begin
               if ((c != version_char(pos_ff[3:0])) || (last && (pos_ff < 5'(VERSION_LEN - 1)))) begin
                  err_in = first_err(err_in, ERR_VERSION);
               end else if (pos_ff >= 5'(VERSION_LEN - 1)) begin
                  if (last) begin
                     err_in = first_err(err_in, ERR_STATUS);
                  end
                  pos_in   = '0;
                  phase_in = PH_STATUS;
               end else begin
                  pos_in = 5'(pos_ff + 5'd1);
               end
            end
            PH_STATUS: begin
               if (head_data.is_digit && (pos_ff < 5'd3) && !last) begin
                  status_in = 10'(status_ff * 10'd10 + 10'(c[3:0]));
                  pos_in    = 5'(pos_ff + 5'd1);
               end else if ((c == CH_SP) && (pos_ff == 5'd3)) begin
                  pos_in   = '0;
                  phase_in = PH_REASON;
                  if (last) begin
                     err_in = first_err(err_in, ERR_REASON);
                  end
               end else begin
                  err_in = first_err(err_in, ERR_STATUS);
               end
            end
            PH_REASON: begin
               if (pcr_ff) begin
                  pcr_in = 1'b0;
                  if ((c != CH_LF) || (pos_ff == 5'd0)) begin
                     err_in = first_err(err_in, ERR_REASON);
                  end else if (last) begin
                     err_in = first_err(err_in, ERR_END);
                  end else begin
                     phase_in = PH_LINE;
                  end
               end else if (c == CH_CR) begin
                  if (last) begin
                     err_in = first_err(err_in, ERR_REASON);
                  end else begin
                     pcr_in = 1'b1;
                  end
               end else if (head_data.is_reason) begin
                  if (pos_ff < 5'd31) begin
                     pos_in = 5'(pos_ff + 5'd1);
                  end
                  if (last) begin
                     err_in = first_err(err_in, ERR_REASON);
                  end
               end else begin
                  err_in = first_err(err_in, ERR_REASON);
               end
            end
            PH_LINE: begin
               if (last) begin
                  err_in = first_err(err_in, ERR_END);
               end else if (c == CH_CR) begin
                  phase_in = PH_BLANK;
               end else begin
                  do_key = 1'b1;
               end
            end
            PH_BLANK: begin
               if (c != CH_LF) begin
                  err_in = first_err(err_in, ERR_KEY);
               end else if (!last) begin
                  phase_in = PH_DONE;
               end
            end
            PH_KEY: begin
               do_key = 1'b1;
            end
            PH_LEAD: begin
               if (last) begin
                  err_in = first_err(err_in, (kind_ff != KIND_NONE) ? ERR_VALUE : ERR_END);
               end else if (c != CH_SP) begin
                  phase_in = PH_VALUE;
                  do_value = 1'b1;
               end
            end
            PH_VALUE: begin
               do_value = 1'b1;
            end
            default: begin
               err_in = first_err(err_in, ERR_END);
            end
         endcase
      end

      if (do_key) begin
         phase_in  = PH_KEY;
         pos_in    = kp_base;
         kmatch_in = km_base;
         if (head_data.is_key) begin
            pos_in    = kp_adv;
            kmatch_in = km_adv;
            if (last) begin
               err_in = first_err(err_in, (kind_adv != KIND_NONE) ? ERR_VALUE : ERR_END);
            end
         end else if (c == CH_COLON) begin
            if (kp_base == 5'd0) begin
               err_in = first_err(err_in, ERR_KEY);
            end else begin
               kind_in = kind_base;
               if (last) begin
                  err_in = first_err(err_in, (kind_base != KIND_NONE) ? ERR_VALUE : ERR_END);
               end else begin
                  vs_in.flags = '0;
                  vs_in.cpos  = '0;
                  pcr_in      = 1'b0;
                  if (kind_base == KIND_LENGTH) begin
                     vs_in.len = '0;
                  end
                  phase_in = PH_LEAD;
               end
            end
         end else begin
            err_in = first_err(err_in, ERR_KEY);
         end
      end

      if (do_value) begin
         if (pcr_ff && (c == CH_LF)) begin
            pcr_in  = 1'b0;
            seen_in = fin_lf.seen;
            err_in  = first_err(err_in, fin_lf.code);
            if (last) begin
               err_in = first_err(err_in, ERR_END);
            end else begin
               phase_in = PH_LINE;
            end
         end else begin
            pcr_in = 1'b0;
            vs_in  = vs_pre;
            if (last) begin
               seen_in = fin_last.seen;
               err_in  = first_err(err_in, fin_last.code);
               err_in  = first_err(err_in, ERR_END);
            end else if (c == CH_CR) begin
               pcr_in = 1'b1;
            end else begin
               vs_in = vs_chr;
            end
         end
      end
   end

   always_comb begin
      ok                              = (err_in == ERR_OK);
      rsp_data_in.error_code          = err_in;
      rsp_data_in.status_value        = (phase_in >= PH_REASON) ? status_in : 10'd0;
      rsp_data_in.content_length      = (ok && seen_in[0]) ? 32'(vs_in.len) : 32'd0;
      rsp_data_in.has_content_length  = ok && seen_in[0];
      rsp_data_in.is_chunked          = ok && seen_in[1];
      rsp_valid_in                    = (head_pop && last) ? 1'b1
                                        : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VERSION;
         pos_ff       <= '0;
         status_ff    <= '0;
         kmatch_ff    <= 2'b11;
         kind_ff      <= KIND_NONE;
         vs_ff        <= '0;
         pcr_ff       <= 1'b0;
         seen_ff      <= '0;
         err_ff       <= ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (head_pop) begin
            if (last) begin
               phase_ff  <= PH_VERSION;
               pos_ff    <= '0;
               status_ff <= '0;
               kmatch_ff <= 2'b11;
               kind_ff   <= KIND_NONE;
               vs_ff     <= '0;
               pcr_ff    <= 1'b0;
               seen_ff   <= '0;
               err_ff    <= ERR_OK;
            end else begin
               phase_ff  <= phase_in;
               pos_ff    <= pos_in;
               status_ff <= status_in;
               kmatch_ff <= kmatch_in;
               kind_ff   <= kind_in;
               vs_ff     <= vs_in;
               pcr_ff    <= pcr_in;
               seen_ff   <= seen_in;
               err_ff    <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hw/rtl/http_response_header_parser.sv
// A flagged beat is queued, then popped into the result register that drives rsp_valid.
// Throughput: one request beat per cycle unless the queue is full (single-pass hrp_back).
// A flagged beat waits in the queue only while the previous result is still unread.
// Reset is synchronous and active high; it empties the byte queue, drops any pending
// result and returns the parser to the start of a new header. No clearing pass follows.
`timescale 1ns / 1ps

// The block splits into a front end and a back end joined by a small byte queue.
// The front end takes request beats whenever the queue has room, tags each byte with
// its character class (digit, key character, reason character, lower-case form) and
// stores it. The back end, unless stalled, pulls one byte per cycle from the queue
// and advances the header grammar: version text, status code, reason phrase, then
// key:value lines and the closing blank line. Content-Length and Transfer-Encoding
// values are checked as they stream by, with spaces at both ends of a value trimmed.
//
// The first error in a header is kept and later bytes of the same header are skipped.
// When the flagged last byte is consumed, the back end loads the result register and
// restarts for the next header, so the following header's bytes can be parsed while
// the result still waits for rsp_ready.
module http_response_header_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hrp_pkg::hrp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hrp_pkg::hrp_rsp_type rsp_data
);
   import hrp_pkg::*;

   // Queue head as seen by the back end.
   logic         head_valid;
   hrp_byte_type head_data;
   logic         head_pop;

   hrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop)
   );

   // The back end only stalls on a flagged byte, and only while the result
   // register still holds the previous header's result.
   hrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hw/rtl/hrp_checker.sv
// Port-level checks for the HTTP response header parser, bound to the top level.
// Depends on hrp_pkg and http_response_header_parser_defines.svh.
`timescale 1ns / 1ps
`include "http_response_header_parser_defines.svh"

module hrp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input hrp_pkg::hrp_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hrp_pkg::hrp_rsp_type rsp_data
);
   import hrp_pkg::*;

   logic in_beat;

   assign in_beat = req_valid && req_ready && req_data.last_byte;

   // A waiting result holds still until it is taken.
   `HRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Any error clears the length and chunked reports.
   `HRP_ASSERT_IMPLY(a_err_clears, clock, reset, rsp_valid && (rsp_data.error_code != ERR_OK), (rsp_data.content_length == 32'd0) && !rsp_data.has_content_length && !rsp_data.is_chunked, "error result carries field data")

   // A length value is only reported together with its flag.
   `HRP_ASSERT_IMPLY(a_len_flag, clock, reset, rsp_valid && !rsp_data.has_content_length, rsp_data.content_length == 32'd0, "length without flag")

   // A status code is three decimal digits at most.
   `HRP_ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid || in_beat, rsp_data.status_value <= 10'd999 || !rsp_valid, "status code out of range")

   // Reset drops any pending result.
   `HRP_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (.*);

>>> dv/http_hdr_check_pkg.sv
// Scoreboard for the HTTP response header parser: a byte-level predictor and a result checker.
// Depends on hrp_pkg for the beat types, the error codes and the size constants.
`timescale 1ns / 1ps

package http_hdr_check_pkg;
   import hrp_pkg::*;

   localparam string VERSION_TEXT      = "HTTP/1.1 ";
   localparam string LENGTH_KEY_TEXT   = "content-length";
   localparam string ENCODING_KEY_TEXT = "transfer-encoding";
   localparam string CHUNKED_TEXT      = "chunked";
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   typedef enum int {
      HDR_VERSION    = 0,
      HDR_STATUS     = 1,
      HDR_REASON     = 2,
      HDR_LINE_START = 3,
      HDR_KEY        = 4,
      HDR_LEAD       = 5,
      HDR_VALUE      = 6,
      HDR_BLANK      = 7,
      HDR_DONE       = 8
   } hdr_phase_type;

   typedef enum int {
      FIELD_NONE    = 0,
      FIELD_LENGTH  = 1,
      FIELD_CHUNKED = 2
   } field_kind_type;

   class header_scoreboard;
      hdr_phase_type   phase;
      int unsigned     pos;
      int unsigned     status_acc;
      bit              len_match;
      bit              te_match;
      field_kind_type  kind;
      longint unsigned len_acc;
      bit              val_nonempty;
      bit              val_space;
      bit              val_bad;
      int unsigned     word_pos;
      bit              cr_held;
      bit              seen_len;
      bit              seen_te;
      err_type         first_err;
      hrp_rsp_type     expected_q[$];
      int unsigned     mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         phase        = HDR_VERSION;
         pos          = 0;
         status_acc   = 0;
         len_match    = 1'b1;
         te_match     = 1'b1;
         kind         = FIELD_NONE;
         len_acc      = 0;
         val_nonempty = 1'b0;
         val_space    = 1'b0;
         val_bad      = 1'b0;
         word_pos     = 0;
         cr_held      = 1'b0;
         seen_len     = 1'b0;
         seen_te      = 1'b0;
         first_err    = ERR_OK;
      endfunction

      function void flag_error(err_type code);
         if (first_err == ERR_OK) first_err = code;
      endfunction

      function field_kind_type key_field();
         if (pos > KEY_NAME_MAX) return FIELD_NONE;
         if (len_match && pos == LENGTH_KEY_TEXT.len()) return FIELD_LENGTH;
         if (te_match && pos == ENCODING_KEY_TEXT.len()) return FIELD_CHUNKED;
         return FIELD_NONE;
      endfunction

      // One untrimmed value byte; a space only counts once something follows it.
      function void value_byte(logic [7:0] c);
         longint unsigned lim;
         longint unsigned d;
         if (c == " ") begin
            if (val_nonempty) val_space = 1'b1;
            return;
         end
         if (val_space) val_bad = 1'b1;
         val_nonempty = 1'b1;
         val_space    = 1'b0;
         if (kind == FIELD_LENGTH) begin
            if (c >= "0" && c <= "9") begin
               lim = (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);
               d   = c - "0";
               if (len_acc > (lim - d) / 10) len_acc = lim;
               else len_acc = len_acc * 10 + d;
            end else begin
               val_bad = 1'b1;
            end
         end else if (kind == FIELD_CHUNKED) begin
            if (word_pos < CHUNKED_TEXT.len() && c == CHUNKED_TEXT[word_pos]) word_pos++;
            else val_bad = 1'b1;
         end
      endfunction

      function void close_field();
         if (kind == FIELD_LENGTH) begin
            if (!val_nonempty || val_bad) flag_error(ERR_VALUE);
            else if (seen_len) flag_error(ERR_DUP);
            else seen_len = 1'b1;
         end else if (kind == FIELD_CHUNKED) begin
            if (val_bad || word_pos != CHUNKED_TEXT.len()) flag_error(ERR_VALUE);
            else if (seen_te) flag_error(ERR_DUP);
            else seen_te = 1'b1;
         end
      endfunction

      function void key_step(logic [7:0] c, bit last);
         logic [7:0] lc;
         bit         key_char;
         key_char = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                    (c >= "A" && c <= "Z") || c == "-";
         if (key_char) begin
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            if (pos >= LENGTH_KEY_TEXT.len() || lc != LENGTH_KEY_TEXT[pos]) len_match = 1'b0;
            if (pos >= ENCODING_KEY_TEXT.len() || lc != ENCODING_KEY_TEXT[pos]) te_match = 1'b0;
            if (pos < 31) pos++;
            if (last) flag_error(key_field() != FIELD_NONE ? ERR_VALUE : ERR_END);
         end else if (c == ":") begin
            if (pos == 0) begin
               flag_error(ERR_KEY);
               return;
            end
            kind = key_field();
            if (last) begin
               flag_error(kind != FIELD_NONE ? ERR_VALUE : ERR_END);
               return;
            end
            val_nonempty = 1'b0;
            val_space    = 1'b0;
            val_bad      = 1'b0;
            word_pos     = 0;
            cr_held      = 1'b0;
            if (kind == FIELD_LENGTH) len_acc = 0;
            phase = HDR_LEAD;
         end else begin
            flag_error(ERR_KEY);
         end
      endfunction

      function void value_step(logic [7:0] c, bit last);
         if (cr_held && c == CHAR_LF) begin
            cr_held = 1'b0;
            close_field();
            if (last) flag_error(ERR_END);
            else phase = HDR_LINE_START;
            return;
         end
         if (cr_held) begin
            cr_held = 1'b0;
            value_byte(CHAR_CR);
         end
         if (last) begin
            close_field();
            flag_error(ERR_END);
            return;
         end
         if (c == CHAR_CR) cr_held = 1'b1;
         else value_byte(c);
      endfunction

      function void advance(logic [7:0] c, bit last);
         case (phase)
            HDR_VERSION: begin
               if (c != VERSION_TEXT[pos] || (last && pos < 8)) begin
                  flag_error(ERR_VERSION);
               end else if (pos >= 8) begin
                  if (last) flag_error(ERR_STATUS);
                  pos   = 0;
                  phase = HDR_STATUS;
               end else begin
                  pos++;
               end
            end
            HDR_STATUS: begin
               if (c >= "0" && c <= "9" && pos < 3 && !last) begin
                  status_acc = status_acc * 10 + (c - "0");
                  pos++;
               end else if (c == " " && pos == 3) begin
                  pos   = 0;
                  phase = HDR_REASON;
                  if (last) flag_error(ERR_REASON);
               end else begin
                  flag_error(ERR_STATUS);
               end
            end
            HDR_REASON: begin
               if (cr_held) begin
                  cr_held = 1'b0;
                  if (c != CHAR_LF || pos == 0) flag_error(ERR_REASON);
                  else if (last) flag_error(ERR_END);
                  else phase = HDR_LINE_START;
               end else if (c == CHAR_CR) begin
                  if (last) flag_error(ERR_REASON);
                  else cr_held = 1'b1;
               end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                            c == " " || c == "-") begin
                  if (pos < 31) pos++;
                  if (last) flag_error(ERR_REASON);
               end else begin
                  flag_error(ERR_REASON);
               end
            end
            HDR_LINE_START: begin
               if (last) begin
                  flag_error(ERR_END);
               end else if (c == CHAR_CR) begin
                  phase = HDR_BLANK;
               end else begin
                  pos       = 0;
                  len_match = 1'b1;
                  te_match  = 1'b1;
                  phase     = HDR_KEY;
                  key_step(c, last);
               end
            end
            HDR_BLANK: begin
               if (c != CHAR_LF) flag_error(ERR_KEY);
               else if (!last) phase = HDR_DONE;
            end
            HDR_KEY: key_step(c, last);
            HDR_LEAD: begin
               if (last) begin
                  flag_error(kind != FIELD_NONE ? ERR_VALUE : ERR_END);
               end else if (c != " ") begin
                  phase = HDR_VALUE;
                  value_step(c, last);
               end
            end
            HDR_VALUE: value_step(c, last);
            default: flag_error(ERR_END);
         endcase
      endfunction

      // Called for every accepted request beat; a flagged beat queues one result.
      function void note_beat(hrp_req_type beat);
         hrp_rsp_type r;
         bit          ok;
         if (first_err == ERR_OK) advance(beat.data_byte, beat.last_byte);
         if (!beat.last_byte) return;
         ok                   = (first_err == ERR_OK);
         r.error_code         = first_err;
         r.status_value       = (phase >= HDR_REASON) ? 10'(status_acc) : 10'd0;
         r.content_length     = (ok && seen_len) ? 32'(len_acc) : 32'd0;
         r.has_content_length = ok && seen_len;
         r.is_chunked         = ok && seen_te;
         expected_q.push_back(r);
         restart();
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(hrp_rsp_type got);
         hrp_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("status_value", want.status_value, got.status_value);
         compare_field("content_length", want.content_length, got.content_length);
         compare_field("has_content_length", want.has_content_length, got.has_content_length);
         compare_field("is_chunked", want.is_chunked, got.is_chunked);
      endfunction
   endclass

endpackage

>>> dv/tb.sv
// Top-level testbench for http_response_header_parser: drives header buffers byte by byte.
// Depends on hrp_pkg and on http_hdr_check_pkg for the scoreboard and its text tables.
`timescale 1ns / 1ps

module tb;
   import hrp_pkg::*;
   import http_hdr_check_pkg::*;

   // Most directed buffers that need a valid first line start from this one.
   localparam string STATUS_LINE = "HTTP/1.1 200 OK\015\012";
   localparam string REASON_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ -";
   localparam string KEY_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
   localparam int unsigned RANDOM_BYTES = 850;
   localparam int unsigned HOLD_CYCLES  = 400;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hrp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hrp_rsp_type rsp_data;

   header_scoreboard sb = new();

   // The header buffer being assembled; its final byte carries the last flag.
   logic [7:0]  hdr_q[$];
   int unsigned bytes_sent   = 0;
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;

   http_response_header_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths for both sides: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Offers one request beat after an optional idle gap. Inputs only change at the
   // falling edge, and the handshake is sampled at the rising edge. With no gap the
   // valid line stays high across consecutive beats, so it is never dropped and raised
   // within one time step.
   task automatic send_beat(input hrp_req_type beat, input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(beat);
   endtask

   task automatic send_buffer();
      hrp_req_type beat;
      for (int i = 0; i < hdr_q.size(); i++) begin
         beat.data_byte = hdr_q[i];
         beat.last_byte = (i == hdr_q.size() - 1);
         send_beat(beat, pick_gap());
      end
      bytes_sent += hdr_q.size();
      hdr_q.delete();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
   endtask

   // Header names are case-insensitive, so each letter flips case at random.
   task automatic put_key(input string name);
      logic [7:0] ch;
      for (int i = 0; i < name.len(); i++) begin
         ch = name[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - 8'd32;
         hdr_q.push_back(ch);
      end
   endtask

   task automatic put_digits(input int unsigned count);
      repeat (count) hdr_q.push_back(8'("0" + $urandom_range(9)));
   endtask

   task automatic put_spaces();
      repeat ($urandom_range(2)) hdr_q.push_back(" ");
   endtask

   task automatic run_text(input string s);
      put_text(s);
      send_buffer();
   endtask

   // Builds a well-formed header with random status, reason and up to max_lines fields.
   // Fields mix the two keys the block knows, near misses of them and unrelated keys.
   // Two length or two encoding lines in one header exercise the duplicate check.
   task automatic build_header(input int unsigned max_lines);
      string base;
      put_text(VERSION_TEXT);
      put_digits(3);
      put_text(" ");
      repeat ($urandom_range(10, 1))
         hdr_q.push_back(REASON_CHARS[$urandom_range(REASON_CHARS.len() - 1)]);
      put_text("\015\012");
      repeat ($urandom_range(max_lines)) begin
         case ($urandom_range(4))
            0, 1: begin
               put_key(LENGTH_KEY_TEXT);
               put_text(":");
               put_spaces();
               case ($urandom_range(7))
                  0:       put_text("4294967295");
                  1:       put_text("4294967296");
                  2:       put_digits($urandom_range(24, 11));
                  default: put_digits($urandom_range(6, 1));
               endcase
               put_spaces();
            end
            2: begin
               put_key(ENCODING_KEY_TEXT);
               put_text(":");
               put_spaces();
               case ($urandom_range(7))
                  0:       put_text("Chunked");
                  1:       put_text("chunk");
                  2:       put_text("chunkedd");
                  3:       put_text("gzip");
                  default: put_text(CHUNKED_TEXT);
               endcase
               put_spaces();
            end
            3: begin
               repeat ($urandom_range(24, 1))
                  hdr_q.push_back(KEY_CHARS[$urandom_range(KEY_CHARS.len() - 1)]);
               put_text(":");
               repeat ($urandom_range(6)) begin
                  if ($urandom_range(4) == 0) hdr_q.push_back(" ");
                  else hdr_q.push_back(8'($urandom_range(126, 33)));
               end
            end
            default: begin
               // Prefixes and extensions of the known keys must not match them.
               base = $urandom_range(1) ? LENGTH_KEY_TEXT : ENCODING_KEY_TEXT;
               case ($urandom_range(2))
                  0:       put_key(base.substr(0, $urandom_range(base.len() - 2)));
                  1:       put_key({base, "s"});
                  default: put_key({base, "-extra-name"});
               endcase
               put_text(": ");
               put_digits($urandom_range(3, 1));
            end
         endcase
         put_text("\015\012");
      end
      put_text("\015\012");
   endtask

   // Result side: ready idles at random, except for one long hold-off that is counted
   // here while the sender keeps offering beats, so the byte queue fills and the block
   // lowers req_ready.
   initial begin : result_side
      int unsigned run_len = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            run_len      = 0;
         end else if (run_len > 0) begin
            run_len--;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(99) < 60) begin
            rsp_ready <= 1'b1;
            run_len = $urandom_range(20);
         end else begin
            rsp_ready <= 1'b0;
            run_len = pick_gap();
         end
      end
   end

   // Every accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin : stimulus
      int unsigned random_start;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffers: a clean header and one for each corner of the grammar.
      run_text({STATUS_LINE, "\015\012"});
      run_text({"HTTP/1.1 404 Not-Found\015\012Content-Length: 0\015\012",
                "TRANSFER-encoding: chunked\015\012\015\012"});
      run_text("HTTP");
      run_text("HTTP/1.0 200 OK\015\012\015\012");
      run_text("HTTP/1.1 ");
      run_text("HTTP/1.1 2000 OK\015\012\015\012");
      run_text("HTTP/1.1 20 OK\015\012\015\012");
      run_text("HTTP/1.1 2x0 OK\015\012\015\012");
      run_text("HTTP/1.1 999 ");
      run_text("HTTP/1.1 200 OK\015X\015\012\015\012");
      run_text("HTTP/1.1 200 \015\012\015\012");
      run_text(STATUS_LINE);
      run_text({STATUS_LINE, "X"});
      run_text({STATUS_LINE, "\015X"});
      run_text({STATUS_LINE, "\015\012X"});
      run_text({STATUS_LINE, "Bad_Key: 1\015\012\015\012"});
      run_text({STATUS_LINE, ": 1\015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length-Extra-Long: zz\015\012\015\012"});
      run_text({STATUS_LINE, "Content-Len"});
      run_text({STATUS_LINE, "Content-Length"});
      run_text({STATUS_LINE, "Content-Length: 12"});
      run_text({STATUS_LINE, "Content-Length: 12a\015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length:  \015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length: 1 2\015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length: 4\0152\015\012\015\012"});
      run_text({STATUS_LINE, "Transfer-Encoding: Chunked\015\012\015\012"});
      run_text({STATUS_LINE, "content-length: 5\015\012Content-Length: 6\015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length:   99999999999   \015\012\015\012"});
      run_text({STATUS_LINE, "Content-Length: 4294967295\015\012\015\012"});

      // Back-to-back short headers while the result side holds off.
      random_start = bytes_sent;
      no_idle      = 1'b1;
      hold_request = 1'b1;
      repeat (8) begin
         build_header(0);
         send_buffer();
      end

      // Random part: mostly well-formed headers with random content, the rest broken
      // by truncation, a replaced byte, an inserted byte or trailing junk, plus a few
      // buffers of pure noise. Some headers run with no idling at all.
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         no_idle = ($urandom_range(7) == 0);
         if ($urandom_range(15) == 0) begin
            repeat ($urandom_range(10, 1)) hdr_q.push_back(8'($urandom_range(255)));
         end else begin
            build_header(3);
            case ($urandom_range(11))
               0: begin
                  random_start = random_start; // keep the count; only the buffer shrinks
                  while (hdr_q.size() > 1 && $urandom_range(3) != 0) void'(hdr_q.pop_back());
               end
               1: hdr_q[$urandom_range(hdr_q.size() - 1)] = 8'($urandom_range(255));
               2: hdr_q.insert($urandom_range(hdr_q.size() - 1), 8'($urandom_range(255)));
               3: hdr_q.push_back(8'($urandom_range(255)));
               default: ;
            endcase
         end
         send_buffer();
      end
      no_idle = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every predicted result, then keep the clock running so that a stray
      // extra result beat would still be caught.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_front.sv
hw/rtl/hrp_back.sv
hw/rtl/http_response_header_parser.sv
hw/rtl/hrp_checker.sv
dv/http_hdr_check_pkg.sv
dv/tb.sv
